// ===== hw/rtl/clqm_pkg.sv =====
package clqm_pkg;

    localparam int NODE_W   = 4;
    localparam int QUEUE_W  = 2;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam int DEFAULT_NODES  = 16;
    localparam int DEFAULT_QUEUES = 4;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LINKED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic               mode;
        logic [QUEUE_W-1:0] queue_id;
        logic [NODE_W-1:0]  node;
    } req_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic [NODE_W-1:0]   head;
        logic                head_valid;
    } rsp_word_t;

    typedef struct packed {
        logic ready;
        logic clear;
        logic accept;
        logic eval;
        logic tail;
        logic push;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic need_tail;
        logic out_room;
    } dp_status_t;

    function automatic logic [10:0] wrap_node(input logic [NODE_W-1:0] v,
                                              input logic [10:0] m);
        logic [10:0] r;
        r = 11'(v);
        for (int i = 0; i < 8; i++) begin
            if (r >= m) begin
                r = r - m;
            end
        end
        return r;
    endfunction

    function automatic logic [6:0] wrap_queue(input logic [QUEUE_W-1:0] v,
                                              input logic [6:0] m);
        logic [6:0] r;
        r = 7'(v);
        for (int i = 0; i < 3; i++) begin
            if (r >= m) begin
                r = r - m;
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/clqm_ctrl.sv =====
module clqm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  clqm_pkg::dp_status_t  status,
    output clqm_pkg::ctl_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_TAIL  = 5'b01000,
        S_PUSH  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = status.need_tail ? S_TAIL : S_PUSH;
            end
            S_TAIL:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (status.out_room)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready  = (state_reg == S_IDLE);
        cmd.clear  = (state_reg == S_CLEAR);
        cmd.accept = (state_reg == S_IDLE) && req_valid;
        cmd.eval   = (state_reg == S_EVAL);
        cmd.tail   = (state_reg == S_TAIL);
        cmd.push   = (state_reg == S_PUSH) && status.out_room;
    end

endmodule

// ===== hw/rtl/clqm_datapath.sv =====
module clqm_datapath #(
    parameter int NODES  = clqm_pkg::DEFAULT_NODES,
    parameter int QUEUES = clqm_pkg::DEFAULT_QUEUES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  clqm_pkg::ctl_cmd_t    cmd,
    output clqm_pkg::dp_status_t  status,
    input  clqm_pkg::req_word_t   req_word,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output clqm_pkg::rsp_word_t   rsp_word
);

    localparam int NIW  = $clog2(NODES);
    localparam int QIW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int CW   = $clog2(NODES + 1);
    localparam int CLR  = (NODES > QUEUES) ? NODES : QUEUES;
    localparam int CLRW = $clog2(CLR);

    logic [NIW-1:0] next_mem   [NODES];
    logic [NIW-1:0] prev_mem   [NODES];
    logic           linked_mem [NODES];
    logic [QIW-1:0] owner_mem  [NODES];
    logic [NIW-1:0] qhead_mem  [QUEUES];
    logic           qne_mem    [QUEUES];
    logic [CW-1:0]  qcnt_mem   [QUEUES];

    logic [CLRW-1:0] clr_reg;
    logic            mode_reg;
    logic [QIW-1:0]  q_reg;
    logic [NIW-1:0]  n_reg;

    logic [NIW-1:0] rd_next_reg;
    logic [NIW-1:0] rd_prev_reg;
    logic           rd_linked_reg;
    logic [QIW-1:0] rd_owner_reg;
    logic [NIW-1:0] rd_qhead_reg;
    logic           rd_qne_reg;
    logic [CW-1:0]  rd_qcnt_reg;

    clqm_pkg::rsp_word_t res_reg;
    clqm_pkg::rsp_word_t res_next;
    clqm_pkg::rsp_word_t rsp_word_reg;
    logic                rsp_valid_reg;

    logic [NIW-1:0] n_in;
    logic [QIW-1:0] q_in;
    logic           clr_in_q;
    logic           clr_in_n;
    logic           op_ok;
    logic           need_tail;
    logic           new_ne;
    logic [NIW-1:0] new_head;
    logic [CW-1:0]  new_cnt;

    logic           q_we;
    logic [QIW-1:0] q_wa;
    logic           t_we;
    logic [NIW-1:0] t_wa;
    logic           t_linked;
    logic           nx_we;
    logic [NIW-1:0] nx_wa;
    logic [NIW-1:0] nx_wd;
    logic           pv_we;
    logic [NIW-1:0] pv_wa;
    logic [NIW-1:0] pv_wd;
    logic           pv_re;
    logic [NIW-1:0] pv_ra;

    assign n_in = NIW'(clqm_pkg::wrap_node(req_word.node, 11'(NODES)));
    assign q_in = QIW'(clqm_pkg::wrap_queue(req_word.queue_id, 7'(QUEUES)));

    assign clr_in_q = (32'(clr_reg) < QUEUES);
    assign clr_in_n = (32'(clr_reg) < NODES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear && (clr_reg != CLRW'(CLR - 1)))
        begin
            clr_reg <= clr_reg + CLRW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= req_word.mode;
            q_reg    <= q_in;
            n_reg    <= n_in;
        end
    end

    // Operation evaluation from the words read at accept time.
    always_comb
    begin
        op_ok     = 1'b0;
        need_tail = 1'b0;
        new_ne    = rd_qne_reg;
        new_head  = rd_qhead_reg;
        new_cnt   = rd_qcnt_reg;
        res_next  = '0;
        if (mode_reg == clqm_pkg::MODE_APPEND)
        begin
            if (rd_linked_reg)
            begin
                res_next.status = clqm_pkg::ST_LINKED;
            end
            else
            begin
                res_next.status = clqm_pkg::ST_OK;
                op_ok     = 1'b1;
                need_tail = rd_qne_reg;
                new_ne    = 1'b1;
                new_head  = rd_qne_reg ? rd_qhead_reg : n_reg;
                new_cnt   = rd_qcnt_reg + CW'(1);
            end
        end
        else
        begin
            if (!rd_qne_reg)
            begin
                res_next.status = clqm_pkg::ST_EMPTY;
            end
            else if (!rd_linked_reg || (rd_owner_reg != q_reg))
            begin
                res_next.status = clqm_pkg::ST_ABSENT;
            end
            else
            begin
                res_next.status = clqm_pkg::ST_OK;
                op_ok = 1'b1;
                if (rd_qhead_reg == n_reg)
                begin
                    if (rd_next_reg == n_reg)
                    begin
                        new_ne   = 1'b0;
                        new_head = '0;
                    end
                    else
                    begin
                        new_head = rd_next_reg;
                    end
                end
                if (rd_qcnt_reg != '0)
                begin
                    new_cnt = rd_qcnt_reg - CW'(1);
                end
            end
        end
        res_next.count      = clqm_pkg::COUNT_W'(new_cnt);
        res_next.head       = new_ne ? clqm_pkg::NODE_W'(new_head) : '0;
        res_next.head_valid = new_ne;
    end

    always_comb
    begin
        q_we     = (cmd.clear && clr_in_q) || (cmd.eval && op_ok);
        q_wa     = cmd.clear ? clr_reg[QIW-1:0] : q_reg;
        t_we     = (cmd.clear && clr_in_n) || (cmd.eval && op_ok);
        t_wa     = cmd.clear ? clr_reg[NIW-1:0] : n_reg;
        t_linked = !cmd.clear && (mode_reg == clqm_pkg::MODE_APPEND);

        nx_we = 1'b0;
        nx_wa = n_reg;
        nx_wd = n_reg;
        pv_we = 1'b0;
        pv_wa = n_reg;
        pv_wd = n_reg;
        if (cmd.eval && op_ok)
        begin
            nx_we = 1'b1;
            pv_we = 1'b1;
            if (mode_reg == clqm_pkg::MODE_APPEND)
            begin
                nx_wa = n_reg;
                nx_wd = rd_qne_reg ? rd_qhead_reg : n_reg;
                pv_wa = rd_qne_reg ? rd_qhead_reg : n_reg;
                pv_wd = n_reg;
            end
            else
            begin
                nx_wa = rd_prev_reg;
                nx_wd = rd_next_reg;
                pv_wa = rd_next_reg;
                pv_wd = rd_prev_reg;
            end
        end
        else if (cmd.tail)
        begin
            nx_we = 1'b1;
            nx_wa = rd_prev_reg;
            nx_wd = n_reg;
            pv_we = 1'b1;
            pv_wa = n_reg;
            pv_wd = rd_prev_reg;
        end

        pv_re = cmd.accept || (cmd.eval && need_tail);
        pv_ra = cmd.accept ? n_in : rd_qhead_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qne_mem[q_wa]   <= cmd.clear ? 1'b0 : new_ne;
            qhead_mem[q_wa] <= cmd.clear ? '0 : new_head;
            qcnt_mem[q_wa]  <= cmd.clear ? '0 : new_cnt;
        end
        if (cmd.accept)
        begin
            rd_qne_reg   <= qne_mem[q_in];
            rd_qhead_reg <= qhead_mem[q_in];
            rd_qcnt_reg  <= qcnt_mem[q_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            linked_mem[t_wa] <= t_linked;
            owner_mem[t_wa]  <= q_reg;
        end
        if (cmd.accept)
        begin
            rd_linked_reg <= linked_mem[n_in];
            rd_owner_reg  <= owner_mem[n_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (cmd.accept)
        begin
            rd_next_reg <= next_mem[n_in];
        end
    end

    // A read and a write at the same address return the old word.
    always_ff @(posedge clk)
    begin
        if (pv_we)
        begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (pv_re)
        begin
            rd_prev_reg <= prev_mem[pv_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            res_reg <= res_next;
        end
        if (cmd.push)
        begin
            rsp_word_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign status.clear_done = (clr_reg == CLRW'(CLR - 1));
    assign status.need_tail  = need_tail;
    assign status.out_room   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

// ===== hw/rtl/circular_linked_queue_manager.sv =====
// Sequence: a request word reads the tables when it is accepted, is evaluated and
// written back, and its result word is registered on the output once it has room;
// an append to a queue that already holds nodes adds a tail step, a read-then-rewrite
// of the link tables. No new word is taken until the last result has been pushed.
// Reset: rst_n clears the controller at once; a clearing pass over max(NODES, QUEUES)
// entries then zeroes the queue table and link flags before the first word is taken.
module circular_linked_queue_manager #(
    parameter int NODES  = clqm_pkg::DEFAULT_NODES,
    parameter int QUEUES = clqm_pkg::DEFAULT_QUEUES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  clqm_pkg::req_word_t  req_word,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output clqm_pkg::rsp_word_t  rsp_word
);

    clqm_pkg::ctl_cmd_t   cmd;
    clqm_pkg::dp_status_t status;

    clqm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .status    (status),
        .cmd       (cmd)
    );

    clqm_datapath #(
        .NODES  (NODES),
        .QUEUES (QUEUES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    assign req_stall = !cmd.ready;

endmodule

// ===== hw/rtl/clqm_checker.sv =====
module clqm_sva (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_stall,
    input logic                 rsp_valid,
    input logic                 rsp_stall,
    input clqm_pkg::rsp_word_t  rsp_word
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("stalled response word changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another word is in work");

    a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_word.head_valid |-> rsp_word.head == '0)
        else $error("empty queue reports a nonzero head");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.head_valid == (rsp_word.count != '0)))
        else $error("head flag disagrees with element count");

    a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.status == clqm_pkg::ST_EMPTY)
            |-> !rsp_word.head_valid && (rsp_word.count == '0))
        else $error("empty refusal on a queue that holds nodes");

endmodule

bind circular_linked_queue_manager clqm_sva u_clqm_sva (.*);

// ===== tb/clqm_checker.sv =====
module clqm_checker
    import clqm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_word_t req_word,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_word_t rsp_word,
    output int        fail_count,
    output int        open_count
);

    localparam int QCOUNT = 4;
    localparam int NCOUNT = 16;

    logic [NODE_W-1:0]  q_head  [QCOUNT];
    logic               q_busy  [QCOUNT];
    logic [COUNT_W-1:0] q_len   [QCOUNT];
    logic [NODE_W-1:0]  fwd     [NCOUNT];
    logic [NODE_W-1:0]  back    [NCOUNT];
    logic               in_use  [NCOUNT];
    logic [QUEUE_W-1:0] owner   [NCOUNT];

    rsp_word_t pending_rsp[$];

    function automatic rsp_word_t apply_request(input req_word_t w);
        logic [QUEUE_W-1:0]  q;
        logic [NODE_W-1:0]   n;
        logic [NODE_W-1:0]   nx;
        logic [NODE_W-1:0]   pv;
        logic [STATUS_W-1:0] st;
        rsp_word_t           r;
        q = w.queue_id;
        n = w.node;
        if (w.mode == MODE_APPEND)
        begin
            if (in_use[n])
            begin
                st = ST_LINKED;
            end
            else
            begin
                st = ST_OK;
                if (!q_busy[q])
                begin
                    q_head[q] = n;
                    q_busy[q] = 1'b1;
                    fwd[n] = n;
                    back[n] = n;
                end
                else
                begin
                    pv = back[q_head[q]];
                    back[n] = pv;
                    fwd[n] = q_head[q];
                    fwd[pv] = n;
                    back[q_head[q]] = n;
                end
                in_use[n] = 1'b1;
                owner[n] = q;
                q_len[q] = q_len[q] + COUNT_W'(1);
            end
        end
        else
        begin
            if (!q_busy[q])
            begin
                st = ST_EMPTY;
            end
            else if (!in_use[n] || owner[n] != q)
            begin
                st = ST_ABSENT;
            end
            else
            begin
                st = ST_OK;
                nx = fwd[n];
                pv = back[n];
                if (q_head[q] == n)
                begin
                    if (nx == n)
                    begin
                        q_busy[q] = 1'b0;
                        q_head[q] = '0;
                    end
                    else
                    begin
                        q_head[q] = nx;
                    end
                end
                fwd[pv] = nx;
                back[nx] = pv;
                in_use[n] = 1'b0;
                if (q_len[q] != '0)
                begin
                    q_len[q] = q_len[q] - COUNT_W'(1);
                end
            end
        end
        r.status = st;
        r.count = q_len[q];
        r.head = q_busy[q] ? q_head[q] : '0;
        r.head_valid = q_busy[q];
        return r;
    endfunction

    task automatic report_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: mismatch in %s, expected %0d, actual %0d", $time, field, want, got);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < QCOUNT; i++)
            begin
                q_head[i] = '0;
                q_busy[i] = 1'b0;
                q_len[i] = '0;
            end
            for (int i = 0; i < NCOUNT; i++)
            begin
                fwd[i] = '0;
                back[i] = '0;
                in_use[i] = 1'b0;
                owner[i] = '0;
            end
            pending_rsp.delete();
            fail_count = 0;
            open_count = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, rsp_word);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    report_field("status", int'(want.status), int'(rsp_word.status));
                    report_field("count", int'(want.count), int'(rsp_word.count));
                    report_field("head", int'(want.head), int'(rsp_word.head));
                    report_field("head_valid", int'(want.head_valid),
                                 int'(rsp_word.head_valid));
                end
            end
            if (req_valid && !req_stall)
            begin
                pending_rsp.push_back(apply_request(req_word));
            end
            open_count = pending_rsp.size();
        end
    end

endmodule

// ===== tb/tb_circular_linked_queue_manager.sv =====
module tb_circular_linked_queue_manager;
    import clqm_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req_word;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp_word;
    int        fail_count;
    int        open_count;
    int        idle_cycles;
    bit        calm;

    logic [NODE_W-1:0] members [4][$];
    bit                linked  [16];

    circular_linked_queue_manager DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_word(req_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word(rsp_word)
    );

    clqm_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_word(req_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word(rsp_word),
        .fail_count(fail_count),
        .open_count(open_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("tb_circular_linked_queue_manager NOT OK");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!(rsp_valid && !rsp_stall));
        end
    end

    task automatic send_word(input req_word_t w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word <= w;
        do
        begin
            @(posedge clk);
        end
        while (!(req_valid && !req_stall));
    endtask

    task automatic put(input logic m, input logic [QUEUE_W-1:0] q, input logic [NODE_W-1:0] n);
        req_word_t w;
        w.mode = m;
        w.queue_id = q;
        w.node = n;
        if (m == MODE_APPEND && !linked[n])
        begin
            members[q].push_back(n);
            linked[n] = 1'b1;
        end
        else if (m == MODE_REMOVE)
        begin
            for (int k = 0; k < members[q].size(); k++)
            begin
                if (members[q][k] == n)
                begin
                    members[q].delete(k);
                    linked[n] = 1'b0;
                    break;
                end
            end
        end
        send_word(w);
    endtask

    task automatic saturate(input logic [QUEUE_W-1:0] q);
        for (int j = 0; j < 4; j++)
        begin
            while (members[j].size() > 0)
            begin
                put(MODE_REMOVE, j[QUEUE_W-1:0], members[j][0]);
            end
        end
        for (int k = 0; k < 16; k++)
        begin
            put(MODE_APPEND, q, k[NODE_W-1:0]);
        end
        put(MODE_APPEND, q + 2'd1, 4'd9);
        put(MODE_REMOVE, q + 2'd2, 4'd3);
    endtask

    initial
    begin
        int                r;
        int                k;
        logic [QUEUE_W-1:0] q;
        logic [NODE_W-1:0]  n;
        int                free_nodes[$];

        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req_word <= '0;
        rsp_stall <= 1'b0;
        idle_cycles <= 0;
        calm = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        put(MODE_REMOVE, 2'd0, 4'd0);
        put(MODE_REMOVE, 2'd3, 4'd15);
        put(MODE_APPEND, 2'd0, 4'd0);
        put(MODE_APPEND, 2'd0, 4'd15);
        put(MODE_APPEND, 2'd3, 4'd15);
        put(MODE_APPEND, 2'd0, 4'd0);
        put(MODE_REMOVE, 2'd0, 4'd5);
        put(MODE_APPEND, 2'd3, 4'd7);
        put(MODE_REMOVE, 2'd3, 4'd15);
        put(MODE_APPEND, 2'd0, 4'd10);
        put(MODE_REMOVE, 2'd0, 4'd15);
        put(MODE_REMOVE, 2'd0, 4'd0);
        put(MODE_REMOVE, 2'd0, 4'd10);
        put(MODE_REMOVE, 2'd3, 4'd7);
        put(MODE_REMOVE, 2'd3, 4'd7);

        for (int i = 0; i < 590; i++)
        begin
            calm = (i >= 200 && i < 260) || (i >= 500 && i < 540);
            if (i == 150)
            begin
                saturate(2'd1);
            end
            if (i == 420)
            begin
                saturate(2'd3);
            end
            r = $urandom_range(0, 99);
            q = QUEUE_W'($urandom_range(0, 3));
            if (r < 45)
            begin
                free_nodes.delete();
                for (k = 0; k < 16; k++)
                begin
                    if (!linked[k])
                    begin
                        free_nodes.push_back(k);
                    end
                end
                if (free_nodes.size() > 0)
                begin
                    n = NODE_W'(free_nodes[$urandom_range(0, free_nodes.size() - 1)]);
                end
                else
                begin
                    n = NODE_W'($urandom_range(0, 15));
                end
                put(MODE_APPEND, q, n);
            end
            else if (r < 85)
            begin
                for (k = 0; k < 4 && members[q].size() == 0; k++)
                begin
                    q = q + 2'd1;
                end
                if (members[q].size() == 0)
                begin
                    n = NODE_W'($urandom_range(0, 15));
                end
                else if ($urandom_range(0, 2) == 0)
                begin
                    n = members[q][0];
                end
                else
                begin
                    n = members[q][$urandom_range(0, members[q].size() - 1)];
                end
                put(MODE_REMOVE, q, n);
            end
            else
            begin
                put(1'($urandom_range(0, 1)), q, NODE_W'($urandom_range(0, 15)));
            end
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        while (open_count != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0 && open_count == 0)
        begin
            $display("tb_circular_linked_queue_manager OK");
        end
        else
        begin
            $display("tb_circular_linked_queue_manager NOT OK");
        end
        $finish;
    end

endmodule
